@@ rtl/tcpg_pkg.sv @@
// Shared constants, types and helpers for the text command pulse generator.
package tcpg_pkg;

    localparam int LINE_LEN  = 12;
    localparam int POS_W     = 4;
    localparam int UNITS_W   = 10;
    localparam int COUNT_W   = 7;
    localparam int PRESC_W   = 20;

    typedef logic [1:0] t_status;
    typedef logic [1:0] t_unit_sel;

    localparam t_status ST_NONE   = 2'd0;
    localparam t_status ST_ACCEPT = 2'd1;
    localparam t_status ST_ERROR  = 2'd2;
    localparam t_status ST_QUERY  = 2'd3;

    localparam t_unit_sel UNIT_SEC  = 2'd0;
    localparam t_unit_sel UNIT_MSEC = 2'd1;
    localparam t_unit_sel UNIT_USEC = 2'd2;

    localparam logic [7:0] CH_G     = 8'h47;  // 'G'
    localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_S     = 8'h73;  // 's'
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_U     = 8'h75;  // 'u'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // ticks per unit; unused code counts as microseconds
    function automatic logic [PRESC_W-1:0] f_unit_ticks(input t_unit_sel sel);
        case (sel)
            UNIT_SEC:  f_unit_ticks = PRESC_W'(1000000);
            UNIT_MSEC: f_unit_ticks = PRESC_W'(1000);
            default:   f_unit_ticks = PRESC_W'(1);
        endcase
    endfunction

endpackage

@@ rtl/text_command_pulse_generator_core.sv @@
// Top level of the text command pulse generator: line parser and pulse timer.
//
// One beat in is either a command character (opcode 0) or a one-microsecond
// tick (opcode 1); each produces exactly one result beat carrying the pulse
// pin level, a status code and the busy flag. Characters build a 12-character
// line "DDDUsDDDUsCC" (U is space, m or u for s, ms, us), which a 'G' executes:
// high time, low time and a two-digit pulse count are decoded and the train
// runs on ticks. '?' reports a query, carriage returns are ignored, and
// characters arriving during a train are dropped. Throughput is one beat per
// clock; a beat passes the input register, then one next-state pass that
// writes the result register. The input stalls only while the result
// register is full and the downstream side stalls it.
module text_command_pulse_generator_core
    import tcpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_pulse_level,
    output t_status    o_status,
    output logic       o_busy_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    // input register
    logic       r_in_valid;
    logic       r_opcode;
    logic [7:0] r_rx_char;

    // block state
    logic [7:0]         r_line_store [LINE_LEN];
    logic [POS_W-1:0]   r_line_pos,    n_line_pos;
    logic [UNITS_W-1:0] r_high_units,  n_high_units;
    logic [UNITS_W-1:0] r_low_units,   n_low_units;
    t_unit_sel          r_high_sel,    n_high_sel;
    t_unit_sel          r_low_sel,     n_low_sel;
    logic [COUNT_W-1:0] r_pulses_left, n_pulses_left;
    t_phase             r_phase,       n_phase;
    logic [UNITS_W-1:0] r_countdown,   n_countdown;
    logic [PRESC_W-1:0] r_prescaler,   n_prescaler;

    // result register
    logic    r_out_valid;
    logic    r_pulse_level;
    t_status r_status;
    logic    r_busy;

    logic    advance;    // result register free to take the next beat
    logic    proc;       // beat in the input register is processed now
    logic    wr_en;      // store the character at the line position
    logic    do_start;   // begin next pulse (high, low or finish)
    t_status n_status;

    // line decode
    logic               line_ok;
    logic               hu_ok, lu_ok;
    t_unit_sel          hu_sel, lu_sel;
    logic [UNITS_W-1:0] dec_high, dec_low;
    logic [COUNT_W-1:0] dec_count;

    // tick path
    logic [PRESC_W-1:0] tick_len;
    logic [PRESC_W-1:0] presc_inc;
    logic [UNITS_W-1:0] cd_dec;

    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // ------------------------------------------------------------------
    // Line check and decimal decode; fixed positions of the line store
    // ------------------------------------------------------------------
    always_comb begin
        line_ok = 1'b1;
        for (int k = 0; k < LINE_LEN; k++) begin
            if (k != 3 && k != 4 && k != 8 && k != 9) begin
                if (!(r_line_store[k] inside {[CH_0:CH_9]})) begin
                    line_ok = 1'b0;
                end
            end
        end

        hu_ok  = 1'b1;
        hu_sel = UNIT_SEC;
        case (r_line_store[3])
            CH_SPACE: hu_sel = UNIT_SEC;
            CH_M:     hu_sel = UNIT_MSEC;
            CH_U:     hu_sel = UNIT_USEC;
            default:  hu_ok  = 1'b0;
        endcase

        lu_ok  = 1'b1;
        lu_sel = UNIT_SEC;
        case (r_line_store[8])
            CH_SPACE: lu_sel = UNIT_SEC;
            CH_M:     lu_sel = UNIT_MSEC;
            CH_U:     lu_sel = UNIT_USEC;
            default:  lu_ok  = 1'b0;
        endcase

        if (r_line_store[4] != CH_S || r_line_store[9] != CH_S || !hu_ok || !lu_ok) begin
            line_ok = 1'b0;
        end

        // low nibble of an ASCII digit is its value
        dec_high  = UNITS_W'(r_line_store[0][3:0]) * UNITS_W'(100)
                  + UNITS_W'(r_line_store[1][3:0]) * UNITS_W'(10)
                  + UNITS_W'(r_line_store[2][3:0]);
        dec_low   = UNITS_W'(r_line_store[5][3:0]) * UNITS_W'(100)
                  + UNITS_W'(r_line_store[6][3:0]) * UNITS_W'(10)
                  + UNITS_W'(r_line_store[7][3:0]);
        dec_count = COUNT_W'(r_line_store[10][3:0]) * COUNT_W'(10)
                  + COUNT_W'(r_line_store[11][3:0]);
    end

    // ------------------------------------------------------------------
    // Next state for the beat in the input register
    // ------------------------------------------------------------------
    always_comb begin
        n_line_pos    = r_line_pos;
        n_high_units  = r_high_units;
        n_low_units   = r_low_units;
        n_high_sel    = r_high_sel;
        n_low_sel     = r_low_sel;
        n_pulses_left = r_pulses_left;
        n_phase       = r_phase;
        n_countdown   = r_countdown;
        n_prescaler   = r_prescaler;
        n_status      = ST_NONE;
        wr_en         = 1'b0;
        do_start      = 1'b0;

        tick_len  = f_unit_ticks((r_phase == PH_HIGH) ? r_high_sel : r_low_sel);
        presc_inc = r_prescaler + PRESC_W'(1);
        cd_dec    = (r_countdown != '0) ? r_countdown - UNITS_W'(1) : '0;

        if (proc) begin
            if (r_opcode) begin
                // tick
                if (r_phase != PH_HIGH && r_phase != PH_LOW) begin
                    n_phase = PH_IDLE;
                end else if (presc_inc < tick_len) begin
                    n_prescaler = presc_inc;
                end else begin
                    n_prescaler = '0;
                    n_countdown = cd_dec;
                    if (cd_dec == '0) begin
                        if (r_phase == PH_HIGH && r_low_units != '0) begin
                            n_phase     = PH_LOW;
                            n_countdown = r_low_units;
                        end else begin
                            if (r_pulses_left != '0) begin
                                n_pulses_left = r_pulses_left - COUNT_W'(1);
                            end
                            do_start = 1'b1;
                        end
                    end
                end
            end else if (r_phase == PH_IDLE && r_rx_char != CH_CR) begin
                // character
                if (r_rx_char == CH_G) begin
                    n_line_pos = '0;
                    if (r_line_pos == POS_W'(LINE_LEN) && line_ok) begin
                        n_high_units  = dec_high;
                        n_low_units   = dec_low;
                        n_high_sel    = hu_sel;
                        n_low_sel     = lu_sel;
                        n_pulses_left = dec_count;
                        do_start      = 1'b1;
                        n_status      = ST_ACCEPT;
                    end else begin
                        n_status = ST_ERROR;
                    end
                end else if (r_rx_char == CH_QUERY) begin
                    n_line_pos = '0;
                    n_status   = ST_QUERY;
                end else if (r_line_pos >= POS_W'(LINE_LEN)) begin
                    n_line_pos = '0;
                    n_status   = ST_ERROR;
                end else begin
                    wr_en      = 1'b1;
                    n_line_pos = r_line_pos + POS_W'(1);
                end
            end
        end

        // pulse start: high phase, else low phase, else end of train
        if (do_start) begin
            n_prescaler = '0;
            if (n_pulses_left == '0) begin
                n_phase     = PH_IDLE;
                n_countdown = '0;
            end else if (n_high_units != '0) begin
                n_phase     = PH_HIGH;
                n_countdown = n_high_units;
            end else if (n_low_units != '0) begin
                n_phase     = PH_LOW;
                n_countdown = n_low_units;
            end else begin
                n_pulses_left = '0;
                n_phase       = PH_IDLE;
                n_countdown   = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers: state and result beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_pos    <= '0;
            r_high_units  <= '0;
            r_low_units   <= '0;
            r_high_sel    <= UNIT_SEC;
            r_low_sel     <= UNIT_SEC;
            r_pulses_left <= '0;
            r_phase       <= PH_IDLE;
            r_countdown   <= '0;
            r_prescaler   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_pulse_level <= (n_phase == PH_HIGH);
                r_status      <= n_status;
                r_busy        <= (n_phase != PH_IDLE);
            end
            r_line_pos    <= n_line_pos;
            r_high_units  <= n_high_units;
            r_low_units   <= n_low_units;
            r_high_sel    <= n_high_sel;
            r_low_sel     <= n_low_sel;
            r_pulses_left <= n_pulses_left;
            r_phase       <= n_phase;
            r_countdown   <= n_countdown;
            r_prescaler   <= n_prescaler;
        end
    end

    // payload: input beat, line store
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_opcode  <= i_opcode;
            r_rx_char <= i_rx_char;
        end
        if (wr_en) begin
            r_line_store[r_line_pos] <= r_rx_char;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pulse_level = r_pulse_level;
    assign o_status      = r_status;
    assign o_busy_res    = r_busy;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_train_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) == (r_pulses_left != '0))
        else $error("pulse count out of step with phase");

    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) == (r_countdown != '0))
        else $error("unit countdown out of step with phase");

    a_line_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_pos <= POS_W'(LINE_LEN))
        else $error("line position past end of line");

    a_presc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_prescaler < tick_len)
        else $error("prescaler past unit length");

    a_status_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && n_status != ST_NONE && n_status != ST_ACCEPT
        |=> r_out_valid && !r_busy)
        else $error("error or query reported during a train");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the text command pulse generator core.
`timescale 1ns / 100ps

module tb_top
    import tcpg_pkg::*;
();

    // opcode of an input beat
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int IDLE_PCT       = 36;    // chance per cycle that a side idles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 8;     // margin after the last result beat
    localparam int MAX_REPORTS    = 10;

    // pulse timer phase as the predictor tracks it
    typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW} t_phase;

    // one result beat: pin level, status code, busy flag
    typedef struct packed {
        logic    level;
        t_status status;
        logic    busy;
    } t_pin_status;

    // a full command line, character 0 first
    typedef logic [LINE_LEN-1:0][7:0] t_line;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_opcode    = 1'b0;
    logic [7:0] i_rx_char   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_pulse_level;
    t_status    o_status;
    logic       o_busy_res;

    // predicted result beats, oldest first
    t_pin_status pending_pins[$];

    int beats_sent   = 0;
    int fail_count   = 0;
    int idle_cycles  = 0;
    bit steady_flow  = 1'b0;  // set: neither side idles

    // ---------------------------------------------------------------
    // Predictor state: line buffer, decoded command and pulse timer
    // ---------------------------------------------------------------
    logic [7:0]         mdl_line [LINE_LEN];
    logic [POS_W-1:0]   mdl_pos;
    logic [UNITS_W-1:0] mdl_high_units;
    logic [UNITS_W-1:0] mdl_low_units;
    t_unit_sel          mdl_high_sel;
    t_unit_sel          mdl_low_sel;
    logic [COUNT_W-1:0] mdl_pulses;      // includes the pulse now running
    t_phase             mdl_phase;
    logic [UNITS_W-1:0] mdl_countdown;   // units left in this phase
    logic [PRESC_W-1:0] mdl_presc;       // ticks into the current unit

    text_command_pulse_generator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_rx_char     (i_rx_char),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pulse_level (o_pulse_level),
        .o_status      (o_status),
        .o_busy_res    (o_busy_res)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    function automatic int digit_value(input logic [7:0] ch);
        return int'(ch) - int'(CH_0);
    endfunction

    // unit letter to select code; 0 when the letter is no unit
    function automatic bit unit_of(input logic [7:0] ch, output t_unit_sel sel);
        sel = UNIT_USEC;
        if (ch == CH_SPACE) sel = UNIT_SEC;
        else if (ch == CH_M) sel = UNIT_MSEC;
        else if (ch != CH_U) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [PRESC_W-1:0] unit_length(input t_unit_sel sel);
        return (sel == UNIT_SEC)  ? PRESC_W'(1_000_000) :
               (sel == UNIT_MSEC) ? PRESC_W'(1000) : PRESC_W'(1);
    endfunction

    function automatic int line_number(input int first);
        return digit_value(mdl_line[first]) * 100 + digit_value(mdl_line[first + 1]) * 10 +
               digit_value(mdl_line[first + 2]);
    endfunction

    function automatic void model_reset();
        mdl_pos        = '0;
        mdl_high_units = '0;
        mdl_low_units  = '0;
        mdl_high_sel   = UNIT_SEC;
        mdl_low_sel    = UNIT_SEC;
        mdl_pulses     = '0;
        mdl_phase      = PH_IDLE;
        mdl_countdown  = '0;
        mdl_presc      = '0;
    endfunction

    // open the next pulse; an empty phase is skipped, two empty phases end the train
    function automatic void model_begin_pulse();
        mdl_presc = '0;
        if (mdl_pulses == 0) begin
            mdl_phase     = PH_IDLE;
            mdl_countdown = '0;
        end else if (mdl_high_units != 0) begin
            mdl_phase     = PH_HIGH;
            mdl_countdown = mdl_high_units;
        end else if (mdl_low_units != 0) begin
            mdl_phase     = PH_LOW;
            mdl_countdown = mdl_low_units;
        end else begin
            mdl_pulses    = '0;
            mdl_phase     = PH_IDLE;
            mdl_countdown = '0;
        end
    endfunction

    function automatic void model_tick();
        logic [PRESC_W-1:0] len;
        if (mdl_phase == PH_IDLE) return;
        len = unit_length(mdl_phase == PH_HIGH ? mdl_high_sel : mdl_low_sel);
        mdl_presc = mdl_presc + 1'b1;
        if (mdl_presc < len) return;
        mdl_presc = '0;
        if (mdl_countdown != 0) mdl_countdown = mdl_countdown - 1'b1;
        if (mdl_countdown != 0) return;
        if (mdl_phase == PH_HIGH && mdl_low_units != 0) begin
            mdl_phase     = PH_LOW;
            mdl_countdown = mdl_low_units;
        end else begin
            if (mdl_pulses != 0) mdl_pulses = mdl_pulses - 1'b1;
            model_begin_pulse();
        end
    endfunction

    // check a full line and start the train
    function automatic t_status model_run_line();
        int        digit_pos[8] = '{0, 1, 2, 5, 6, 7, 10, 11};
        t_unit_sel hs;
        t_unit_sel ls;
        foreach (digit_pos[k])
            if (!is_digit(mdl_line[digit_pos[k]])) return ST_ERROR;
        if (mdl_line[4] != CH_S || mdl_line[9] != CH_S) return ST_ERROR;
        if (!unit_of(mdl_line[3], hs) || !unit_of(mdl_line[8], ls)) return ST_ERROR;
        mdl_high_units = UNITS_W'(line_number(0));
        mdl_low_units  = UNITS_W'(line_number(5));
        mdl_high_sel   = hs;
        mdl_low_sel    = ls;
        mdl_pulses     = COUNT_W'(digit_value(mdl_line[10]) * 10 + digit_value(mdl_line[11]));
        model_begin_pulse();
        return ST_ACCEPT;
    endfunction

    function automatic t_status model_char(input logic [7:0] ch);
        t_status st;
        // dropped while a train runs; CR is always dropped
        if (mdl_phase != PH_IDLE || ch == CH_CR) return ST_NONE;
        if (ch == CH_G) begin
            st = (mdl_pos == LINE_LEN) ? model_run_line() : ST_ERROR;
            mdl_pos = '0;
            return st;
        end
        if (ch == CH_QUERY) begin
            mdl_pos = '0;
            return ST_QUERY;
        end
        if (mdl_pos >= LINE_LEN) begin
            // overflow
            mdl_pos = '0;
            return ST_ERROR;
        end
        mdl_line[mdl_pos] = ch;
        mdl_pos = mdl_pos + 1'b1;
        return ST_NONE;
    endfunction

    function automatic t_pin_status predict_pins(input logic op, input logic [7:0] ch);
        t_pin_status r;
        r.status = ST_NONE;
        if (op == OP_TICK) model_tick();
        else r.status = model_char(ch);
        r.level = (mdl_phase == PH_HIGH);
        r.busy  = (mdl_phase != PH_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Beat driver
    // ---------------------------------------------------------------
    // Random gaps before the beat; valid then holds until the beat is taken.
    // The prediction is made at the accepting edge, so stimulus code can look
    // at the predictor to see where the block stands.
    task automatic send_beat(input logic op, input logic [7:0] ch);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_char  <= ch;
        do @(posedge i_clk); while (o_in_stall);
        pending_pins.push_back(predict_pins(op, ch));
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_beat(OP_CHAR, ch);
    endtask

    // rx_char is don't-care on a tick, so it carries random bits
    task automatic send_tick();
        send_beat(OP_TICK, 8'($urandom_range(255)));
    endtask

    // ---------------------------------------------------------------
    // Command building
    // ---------------------------------------------------------------
    function automatic logic [7:0] digit_char(input int v);
        return CH_0 + 8'(v % 10);
    endfunction

    function automatic t_line build_line(input int hv, input logic [7:0] hu, input int lv,
                                         input logic [7:0] lu, input int cnt);
        t_line ln;
        ln[0]  = digit_char(hv / 100);
        ln[1]  = digit_char(hv / 10);
        ln[2]  = digit_char(hv);
        ln[3]  = hu;
        ln[4]  = CH_S;
        ln[5]  = digit_char(lv / 100);
        ln[6]  = digit_char(lv / 10);
        ln[7]  = digit_char(lv);
        ln[8]  = lu;
        ln[9]  = CH_S;
        ln[10] = digit_char(cnt / 10);
        ln[11] = digit_char(cnt);
        return ln;
    endfunction

    function automatic logic [7:0] random_unit();
        case ($urandom_range(2))
            0:       return CH_SPACE;
            1:       return CH_M;
            default: return CH_U;
        endcase
    endfunction

    // a byte that fits no position of a line and does not frame one
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_digit(b) || b == CH_SPACE || b == CH_M || b == CH_U || b == CH_S ||
               b == CH_G || b == CH_QUERY || b == CH_CR)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // first n characters of a line, CRs sprinkled in at cr_pct percent
    task automatic send_line(input t_line ln, input int n, input int cr_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < cr_pct) send_char(CH_CR);
            send_char(ln[k]);
        end
    endtask

    // stray characters in flight get dropped; mostly ticks
    task automatic run_out_train();
        while (mdl_phase != PH_IDLE) begin
            if ($urandom_range(99) < 15) send_char(8'($urandom_range(255)));
            else send_tick();
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset();
        model_reset();
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // tick while idle, CR, query, G on an empty line, a stored byte cleared by a query
    task automatic test_idle_handling();
        send_beat(OP_TICK, 8'hFF);
        send_char(CH_CR);
        send_char(CH_QUERY);
        send_char(CH_G);
        send_beat(OP_CHAR, 8'h00);
        send_char(CH_QUERY);
    endtask

    // 2 us high, empty low phase, one pulse; a G during the train is dropped
    task automatic test_single_pulse();
        send_line(build_line(2, CH_U, 0, CH_U, 1), LINE_LEN, 0);
        send_char(CH_G);
        send_char(CH_G);
        send_tick();
        send_tick();
    endtask

    // Mostly good commands with random content, run to the end of their train;
    // the rest broken lines, queries and noise.
    task automatic test_random_commands(input int beats);
        int         stop_at;
        int         pick;
        int         hv;
        int         lv;
        int         cnt;
        int         n;
        logic [7:0] hu;
        logic [7:0] lu;
        t_line      ln;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            // clear leftovers so a good line starts at position zero
            if (pick < 95 && mdl_pos != 0) send_char(CH_QUERY);
            if (pick < 60) begin
                // runnable train, short and in microseconds; seconds only as an empty phase
                hv  = $urandom_range(6);
                lv  = $urandom_range(6);
                cnt = $urandom_range(4);
                hu  = CH_U;
                lu  = CH_U;
                if ($urandom_range(99) < 8) begin
                    hu = CH_SPACE;
                    hv = 0;
                end
                if ($urandom_range(99) < 8) begin
                    lu = CH_SPACE;
                    lv = 0;
                end
                send_line(build_line(hv, hu, lv, lu, cnt), LINE_LEN, 10);
                send_char(CH_G);
            end else if (pick < 72) begin
                // full digit range, but no pulse or an instantly ending train
                hv  = $urandom_range(999);
                lv  = $urandom_range(999);
                cnt = $urandom_range(99);
                if ($urandom_range(1)) cnt = 0;
                else begin
                    hv = 0;
                    lv = 0;
                end
                send_line(build_line(hv, random_unit(), lv, random_unit(), cnt), LINE_LEN, 5);
                send_char(CH_G);
            end else if (pick < 80) begin
                // bad format: one position holds a wrong byte
                ln = build_line(0, random_unit(), 0, random_unit(), $urandom_range(99));
                ln[$urandom_range(LINE_LEN - 1)] = junk_byte();
                send_line(ln, LINE_LEN, 0);
                send_char(CH_G);
            end else if (pick < 86) begin
                // G before the line is full
                n = $urandom_range(LINE_LEN - 1);
                send_line(build_line(0, CH_U, 0, CH_U, 1), n, 0);
                send_char(CH_G);
            end else if (pick < 92) begin
                // overflow, then a G on what is left
                send_line(build_line(0, CH_U, 0, CH_U, 1), LINE_LEN, 0);
                n = $urandom_range(1, 2);
                repeat (n) send_char(junk_byte());
                send_char(CH_G);
            end else if (pick < 95) begin
                // query anywhere in a line
                n = $urandom_range(LINE_LEN);
                send_line(build_line(1, CH_U, 1, CH_U, 1), n, 0);
                send_char(CH_QUERY);
            end else begin
                // noise; at most six beats of ticks and stray bytes
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(1)) send_tick();
                    else send_char(junk_byte() ^ 8'($urandom_range(1) ? 8'h00 : 8'h80));
                end
            end
            run_out_train();
            if ($urandom_range(99) < 20) repeat ($urandom_range(1, 3)) send_tick();
        end
    endtask

    // same traffic with both sides always ready
    task automatic test_steady_stream(input int beats);
        steady_flow = 1'b1;
        test_random_commands(beats);
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall, checker, watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_pin_status want;
        t_pin_status got;
        got = '{level: o_pulse_level, status: o_status, busy: o_busy_res};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pins.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: level=%0d status=%0d busy=%0d",
                             got.level, got.status, got.busy);
            end else begin
                want = pending_pins.pop_front();
                if (got.level !== want.level || got.status !== want.status ||
                    got.busy !== want.busy) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: expected level=%0d status=%0d busy=%0d, ",
                                  "got level=%0d status=%0d busy=%0d"},
                                 want.level, want.status, want.busy,
                                 got.level, got.status, got.busy);
                end
            end
        end
        // watchdog: any handshake on either side resets it
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        test_reset();
        test_idle_handling();
        test_single_pulse();
        test_random_commands(500);
        test_steady_stream(150);
        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
